// ===== src/skpq_pkg.sv =====
package skpq_pkg;

	// default sizes
	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_BITS_DEF  = 32;
	localparam int DATA_BITS_DEF = 32;

	// cells per partial or-group of the extracted payload
	localparam int GROUP_SIZE = 8;

	localparam int STATUS_BITS = 3;

	// operation codes
	localparam logic [1:0] MODE_INSERT      = 2'd0;
	localparam logic [1:0] MODE_EXTRACT_MIN = 2'd1;
	localparam logic [1:0] MODE_EXTRACT_KEY = 2'd2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_MISSING   = 3'd3,
		ST_EXTRACTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REDUCE,
		S_UPDATE
	} state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic capture;   // latch compare flags against the incoming key
		logic ins;       // insert at the first cell whose key is not below
		logic shift_all; // every cell takes its right neighbor
		logic shift_hit; // cells from the match upward take their right neighbor
	} cell_ctrl_t;

endpackage

// ===== src/skpq_req_if.sv =====
interface skpq_req_if #(
	parameter int KEY_BITS  = skpq_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = skpq_pkg::DATA_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  mode;
	logic signed [KEY_BITS-1:0]  key;
	logic [DATA_BITS-1:0]        payload;

	modport source (output valid, output mode, output key, output payload, input ready);
	modport sink (input valid, input mode, input key, input payload, output ready);
endinterface

// ===== src/skpq_rsp_if.sv =====
interface skpq_rsp_if #(
	parameter int KEY_BITS  = skpq_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = skpq_pkg::DATA_BITS_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic [skpq_pkg::STATUS_BITS-1:0]      status;
	logic signed [KEY_BITS-1:0]            key_out;
	logic [DATA_BITS-1:0]                  data_out;

	modport source (output valid, output status, output key_out, output data_out, input ready);
	modport sink (input valid, input status, input key_out, input data_out, output ready);
endinterface

// ===== src/skpq_cell.sv =====
module skpq_cell #(
	parameter int KEY_BITS  = skpq_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = skpq_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  skpq_pkg::cell_ctrl_t        ctrl,
	input  logic                        occupied,
	input  logic signed [KEY_BITS-1:0]  cmp_key,
	input  logic signed [KEY_BITS-1:0]  ins_key,
	input  logic [DATA_BITS-1:0]        ins_data,
	input  logic                        left_ge,
	input  logic signed [KEY_BITS-1:0]  left_key,
	input  logic [DATA_BITS-1:0]        left_data,
	input  logic signed [KEY_BITS-1:0]  right_key,
	input  logic [DATA_BITS-1:0]        right_data,
	output logic signed [KEY_BITS-1:0]  key,
	output logic [DATA_BITS-1:0]        data,
	output logic                        ge,
	output logic                        eq
);
	import skpq_pkg::*;

	logic signed [KEY_BITS-1:0] key_q;
	logic [DATA_BITS-1:0]       data_q;
	logic                       ge_q;
	logic                       eq_q;

	// compare flags, taken when an operation is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.capture) begin
			ge_q <= !occupied || (key_q >= cmp_key);
			eq_q <= occupied && (key_q == cmp_key);
		end
	end

	// entry shift: right on insert, left on extract
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (ge_q && !left_ge) begin
				key_q  <= ins_key;
				data_q <= ins_data;
			end else if (ge_q) begin
				key_q  <= left_key;
				data_q <= left_data;
			end
		end else if (ctrl.shift_all || (ctrl.shift_hit && ge_q)) begin
			key_q  <= right_key;
			data_q <= right_data;
		end
	end

	assign key  = key_q;
	assign data = data_q;
	assign ge   = ge_q;
	assign eq   = eq_q;

endmodule

// ===== src/sorted_key_priority_queue.sv =====
// Sorted-key priority queue built as a row of cells, slot 0 holding the smallest key.
// req channel: mode (insert, extract minimum, extract by key), key and payload.
// rsp channel: one result per request with status, key_out and data_out;
// key_out and data_out are zero unless the status is extracted.
// Each cell compares its own key with the request key when the request is
// transferred and registers the flags. The reduce step then ORs the match
// flags and gathers the matching payload in groups of eight cells, and the
// update step shifts the row by one slot and loads the result register.
// A new request is taken only once the previous one has left the update
// step, as each request goes through the compare, gather and shift steps in turn.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls that long, the following shift step waits
// until the output register is free.
// Reset empties the queue at once (the entry count clears); no clearing pass.
module sorted_key_priority_queue #(
	parameter int CAPACITY  = skpq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS  = skpq_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = skpq_pkg::DATA_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	skpq_req_if.sink   req,
	skpq_rsp_if.source rsp
);
	import skpq_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

	state_t state_q, state_d;

	logic [1:0]                 mode_s1;
	logic signed [KEY_BITS-1:0] key_s1;
	logic [DATA_BITS-1:0]       data_s1;

	logic [CNT_W-1:0] count_q, count_d;
	logic             found_q;
	logic [DATA_BITS-1:0] part_q [GROUPS];
	logic [DATA_BITS-1:0] part_d [GROUPS];

	logic                       out_valid_q;
	status_t                    status_q;
	logic signed [KEY_BITS-1:0] key_out_q;
	logic [DATA_BITS-1:0]       data_out_q;

	cell_ctrl_t                 ctrl;
	logic                       upd_fire;
	logic                       full;
	status_t                    status_c;
	logic signed [KEY_BITS-1:0] key_c;
	logic [DATA_BITS-1:0]       data_c;
	logic [DATA_BITS-1:0]       sel_data;

	logic signed [KEY_BITS-1:0] cell_key  [CAPACITY];
	logic [DATA_BITS-1:0]       cell_data [CAPACITY];
	logic [CAPACITY-1:0]        ge_vec;
	logic [CAPACITY-1:0]        eq_vec;

	assign req.ready = (state_q == S_IDLE);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign upd_fire  = (state_q == S_UPDATE) && (!out_valid_q || rsp.ready);

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                       occ;
		logic                       l_ge;
		logic signed [KEY_BITS-1:0] l_key;
		logic [DATA_BITS-1:0]       l_data;
		logic signed [KEY_BITS-1:0] r_key;
		logic [DATA_BITS-1:0]       r_data;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign l_ge   = 1'b0;
			assign l_key  = key_s1;
			assign l_data = data_s1;
		end else begin : g_mid
			assign l_ge   = ge_vec[i-1];
			assign l_key  = cell_key[i-1];
			assign l_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_key  = cell_key[i];
			assign r_data = cell_data[i];
		end else begin : g_inner
			assign r_key  = cell_key[i+1];
			assign r_data = cell_data[i+1];
		end

		skpq_cell #(
			.KEY_BITS (KEY_BITS),
			.DATA_BITS(DATA_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.occupied  (occ),
			.cmp_key   (req.key),
			.ins_key   (key_s1),
			.ins_data  (data_s1),
			.left_ge   (l_ge),
			.left_key  (l_key),
			.left_data (l_data),
			.right_key (r_key),
			.right_data(r_data),
			.key       (cell_key[i]),
			.data      (cell_data[i]),
			.ge        (ge_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	// request register
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1 <= req.mode;
			key_s1  <= req.key;
			data_s1 <= req.payload;
		end
	end

	// payload of the matching cell, or-ed in groups
	always_comb begin
		int idx;
		for (int g = 0; g < GROUPS; g++) begin
			part_d[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				idx = g * GROUP_SIZE + j;
				if (idx < CAPACITY) begin
					if (eq_vec[idx]) begin
						part_d[g] = part_d[g] | cell_data[idx];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REDUCE) begin
			found_q <= |eq_vec;
			part_q  <= part_d;
		end
	end

	// final or of the groups
	always_comb begin
		sel_data = '0;
		for (int g = 0; g < GROUPS; g++) begin
			sel_data = sel_data | part_q[g];
		end
	end

	// operation decode and cell control
	always_comb begin
		ctrl         = '0;
		ctrl.capture = req.valid && req.ready;
		status_c     = ST_MISSING;
		key_c        = '0;
		data_c       = '0;
		count_d      = count_q;
		case (mode_s1)
			MODE_INSERT: begin
				if (full) begin
					status_c = ST_FULL;
				end else if (found_q) begin
					status_c = ST_DUPLICATE;
				end else begin
					status_c = ST_INSERTED;
					ctrl.ins = upd_fire;
					count_d  = count_q + CNT_W'(1);
				end
			end
			MODE_EXTRACT_MIN: begin
				if (count_q != '0) begin
					status_c       = ST_EXTRACTED;
					key_c          = cell_key[0];
					data_c         = cell_data[0];
					ctrl.shift_all = upd_fire;
					count_d        = count_q - CNT_W'(1);
				end
			end
			MODE_EXTRACT_KEY: begin
				if (found_q) begin
					status_c       = ST_EXTRACTED;
					key_c          = key_s1;
					data_c         = sel_data;
					ctrl.shift_hit = upd_fire;
					count_d        = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_c = ST_MISSING;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_REDUCE;
			end
			S_REDUCE: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (upd_fire) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (upd_fire) begin
			count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			status_q   <= status_c;
			key_out_q  <= key_c;
			data_out_q <= data_c;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = status_q;
	assign rsp.key_out  = key_out_q;
	assign rsp.data_out = data_out_q;

`ifndef ASSERT_OFF
	// entry count stays within the row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// keys are unique, so at most one cell matches
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_vec))
		else $error("more than one cell matches the key");

	// an insert grows the queue by one entry
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && status_c == ST_INSERTED) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance the entry count");

	// an extraction needs a stored entry
	a_extract_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && status_c == ST_EXTRACTED) |-> count_q != '0)
		else $error("extraction from an empty queue");

	// cell shifts only in the update step
	a_shift_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.ins || ctrl.shift_all || ctrl.shift_hit) |-> state_q == S_UPDATE)
		else $error("cell shift outside the update step");
`endif

endmodule
